// ===== hw/rtl/png_su_pkg.sv =====
// png_su_pkg: shared types, constants and helpers for the PNG scanline unfilter.
// No dependencies; every other file in hw/rtl refers to it by scoped name.
package png_su_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_BPP    = 4;

    localparam int LINE_DEPTH = MAX_WIDTH * MAX_BPP;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
    localparam int BPP_IDX_W  = $clog2(MAX_BPP);
    localparam int CFG_W      = 13;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } t_filter;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FILTER = 2'd1,
        ST_BAD_COLOR  = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_COLOR  = 2'd2
    } t_cfg_idx;

    // color type codes
    localparam logic [2:0] CT_GRAY       = 3'd0;
    localparam logic [2:0] CT_RGB        = 3'd2;
    localparam logic [2:0] CT_PALETTE    = 3'd3;
    localparam logic [2:0] CT_GRAY_ALPHA = 3'd4;
    localparam logic [2:0] CT_RGBA       = 3'd6;

    // bytes per pixel minus one, unknown types map to one byte
    function automatic logic [BPP_IDX_W-1:0] bpp_idx(input logic [2:0] ct);
        logic [BPP_IDX_W-1:0] v;
        case (ct)
            CT_GRAY:       v = BPP_IDX_W'(0);
            CT_RGB:        v = BPP_IDX_W'(2);
            CT_PALETTE:    v = BPP_IDX_W'(0);
            CT_GRAY_ALPHA: v = BPP_IDX_W'(1);
            CT_RGBA:       v = BPP_IDX_W'(3);
            default:       v = BPP_IDX_W'(0);
        endcase
        return v;
    endfunction

    function automatic logic color_bad(input logic [2:0] ct);
        logic v;
        case (ct)
            CT_GRAY, CT_RGB, CT_PALETTE, CT_GRAY_ALPHA, CT_RGBA: v = 1'b0;
            default: v = 1'b1;
        endcase
        return v;
    endfunction

    // fields carried from the accept stage to the reconstruct stage
    typedef struct packed {
        t_byte   x;
        logic    first_row;
        logic    last_col;
        logic    last_row;
        t_status status;
    } t_s1_ctl;

endpackage

// ===== hw/rtl/png_su_if.sv =====
// Valid/ready channel interfaces for the PNG scanline unfilter.
// Depends on png_su_pkg for the byte and status types.
interface png_su_byte_if;
    logic                valid;
    logic                ready;
    png_su_pkg::t_byte   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface png_su_pix_if;
    logic                valid;
    logic                ready;
    png_su_pkg::t_byte   pixel_byte;
    logic                row_end;
    logic                image_end;
    png_su_pkg::t_status status;

    modport source (output valid, output pixel_byte, output row_end, output image_end,
                    output status, input ready);
    modport sink   (input valid, input pixel_byte, input row_end, input image_end,
                    input status, output ready);
endinterface

// ===== hw/rtl/png_su_line_ram.sv =====
// Previous-row line store: one write port, one read port, registered read.
// Depends on png_su_pkg for depth and address width.
module png_su_line_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [png_su_pkg::ADDR_W-1:0] i_waddr,
    input  png_su_pkg::t_byte             i_wdata,
    input  logic                          i_re,
    input  logic [png_su_pkg::ADDR_W-1:0] i_raddr,
    output png_su_pkg::t_byte             o_rdata
);

    png_su_pkg::t_byte r_mem [png_su_pkg::LINE_DEPTH];
    png_su_pkg::t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/png_su_predict.sv =====
// Filter reconstruction datapath: None, Sub, Up, Average and Paeth.
// Depends on png_su_pkg for the filter type.
module png_su_predict (
    input  png_su_pkg::t_filter i_filter,
    input  png_su_pkg::t_byte   i_x,
    input  png_su_pkg::t_byte   i_a,
    input  png_su_pkg::t_byte   i_b,
    input  png_su_pkg::t_byte   i_c,
    output png_su_pkg::t_byte   o_r
);

    logic [8:0]        sum_ab;
    logic signed [9:0] d_bc, d_ac, d_abc;
    logic [9:0]        pa, pb, pc;
    png_su_pkg::t_byte pred_paeth;

    always_comb begin
        sum_ab = {1'b0, i_a} + {1'b0, i_b};
        // p - a = b - c, p - b = a - c, p - c = a + b - 2c
        d_bc   = $signed({2'b00, i_b}) - $signed({2'b00, i_c});
        d_ac   = $signed({2'b00, i_a}) - $signed({2'b00, i_c});
        d_abc  = d_bc + d_ac;
        pa     = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
        pb     = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
        pc     = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);
        if (pa <= pb && pa <= pc) begin
            pred_paeth = i_a;
        end else if (pb <= pc) begin
            pred_paeth = i_b;
        end else begin
            pred_paeth = i_c;
        end

        case (i_filter)
            png_su_pkg::FLT_SUB:   o_r = i_x + i_a;
            png_su_pkg::FLT_UP:    o_r = i_x + i_b;
            png_su_pkg::FLT_AVG:   o_r = i_x + sum_ab[8:1];
            png_su_pkg::FLT_PAETH: o_r = i_x + pred_paeth;
            default:               o_r = i_x;
        endcase
    end

endmodule

// ===== hw/rtl/png_su_top_dummy_guard.sv =====
// Row/column sequencer for the PNG scanline unfilter: tracks filter bytes,
// byte position and row count, and supplies the line store read address. Depends on png_su_pkg.
module png_su_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  png_su_pkg::t_byte             i_data,
    input  logic [png_su_pkg::CFG_W-1:0]  i_width,
    input  logic [png_su_pkg::CFG_W-1:0]  i_height,
    input  logic [2:0]                    i_color,
    input  logic                          i_bad_filter,
    output logic                          o_expect_filter,
    output logic [png_su_pkg::ADDR_W-1:0] o_pos,
    output png_su_pkg::t_s1_ctl           o_ctl
);

    logic [png_su_pkg::ADDR_W-1:0] r_pos, n_pos;
    logic                          r_expect, n_expect;
    logic [png_su_pkg::ROW_W-1:0]  r_row, n_row;
    logic                          r_first, n_first;

    logic [png_su_pkg::CFG_W-1:0]  w_eff, h_eff;
    logic [png_su_pkg::LEN_W-1:0]  len;
    logic                          last_col, last_row;

    always_comb begin
        if (i_width == '0) begin
            w_eff = png_su_pkg::CFG_W'(1);
        end else if (i_width > png_su_pkg::CFG_W'(png_su_pkg::MAX_WIDTH)) begin
            w_eff = png_su_pkg::CFG_W'(png_su_pkg::MAX_WIDTH);
        end else begin
            w_eff = i_width;
        end
        if (i_height == '0) begin
            h_eff = png_su_pkg::CFG_W'(1);
        end else if (i_height > png_su_pkg::CFG_W'(png_su_pkg::MAX_HEIGHT)) begin
            h_eff = png_su_pkg::CFG_W'(png_su_pkg::MAX_HEIGHT);
        end else begin
            h_eff = i_height;
        end
        len = png_su_pkg::LEN_W'(w_eff) *
              png_su_pkg::LEN_W'({1'b0, png_su_pkg::bpp_idx(i_color)} + 3'd1);
        last_col = (png_su_pkg::LEN_W'(r_pos) + png_su_pkg::LEN_W'(1)) >= len;
        last_row = ({1'b0, r_row} + png_su_pkg::CFG_W'(1)) >= h_eff;

        o_ctl.x         = i_data;
        o_ctl.first_row = r_first;
        o_ctl.last_col  = last_col;
        o_ctl.last_row  = last_row;
        if (png_su_pkg::color_bad(i_color)) begin
            o_ctl.status = png_su_pkg::ST_BAD_COLOR;
        end else if (i_bad_filter) begin
            o_ctl.status = png_su_pkg::ST_BAD_FILTER;
        end else begin
            o_ctl.status = png_su_pkg::ST_OK;
        end

        n_pos    = r_pos;
        n_expect = r_expect;
        n_row    = r_row;
        n_first  = r_first;
        if (i_accept) begin
            if (r_expect) begin
                n_expect = 1'b0;
                n_pos    = '0;
            end else if (last_col) begin
                n_expect = 1'b1;
                if (last_row) begin
                    n_row   = '0;
                    n_first = 1'b1;
                end else begin
                    n_row   = r_row + png_su_pkg::ROW_W'(1);
                    n_first = 1'b0;
                end
            end else begin
                n_pos = r_pos + png_su_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_expect <= 1'b1;
            r_row    <= '0;
            r_first  <= 1'b1;
        end else begin
            r_pos    <= n_pos;
            r_expect <= n_expect;
            r_row    <= n_row;
            r_first  <= n_first;
        end
    end

    assign o_expect_filter = r_expect;
    assign o_pos           = r_pos;

endmodule

// ===== hw/rtl/png_scanline_unfilter_unit.sv =====
// PNG scanline unfilter, top level: sequencer, line store, reconstruct stage
// and output register. Depends on png_su_pkg, png_su_if and the png_su_* modules.
//
// Usage:
//   i_byte carries the inflated stream, one byte per item. The first byte of
//   each row is its filter type and yields no result; every following byte of
//   the row yields one o_pix item with the reconstructed byte, row/image end
//   marks and a status code. Bytes per row = width times bytes per pixel.
//   Configuration (width, height, color type) is written through
//   i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle.
// Throughput and stages:
//   One item per cycle sustained while o_pix is ready. A sample byte reads the
//   line store as it is accepted into the reconstruct stage, is reconstructed
//   in the following cycle and then passes to the output register that drives
//   o_pix. The line store's registered read overlaps the reconstruct stage;
//   filter bytes are accepted but yield no result.
// Reset and stall:
//   Synchronous active-low reset returns to a filter byte of a new first row
//   with width 1, height 1, color type 0. The line store has no reset; the
//   first row masks its data to zero. When o_pix stalls, the output register
//   holds, the reconstruct stage fills and then i_byte.ready drops.
module png_scanline_unfilter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    png_su_byte_if.sink                       i_byte,
    png_su_pix_if.source                      o_pix,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [png_su_pkg::CFG_W-1:0]      i_cfg_data
);

    // configuration
    logic [png_su_pkg::CFG_W-1:0] r_width, r_height;
    logic [2:0]                   r_color;

    // per-row state set by the filter byte
    png_su_pkg::t_filter r_filter;
    logic                r_bad_filter;

    // left and above-left history, newest at index 0
    png_su_pkg::t_byte r_left [png_su_pkg::MAX_BPP];
    png_su_pkg::t_byte r_upl  [png_su_pkg::MAX_BPP];

    // reconstruct stage
    logic                          r_s1_valid;
    png_su_pkg::t_s1_ctl           r_s1;
    logic [png_su_pkg::ADDR_W-1:0] r_s1_pos;

    // output register
    logic                r_out_valid;
    png_su_pkg::t_byte   r_out_byte;
    logic                r_out_row_end, r_out_img_end;
    png_su_pkg::t_status r_out_status;

    logic                          accept, s1_adv, expect_filter, sample_acc;
    logic [png_su_pkg::ADDR_W-1:0] pos;
    png_su_pkg::t_s1_ctl           s0_ctl;
    png_su_pkg::t_byte             above_rd, a_byte, b_byte, c_byte, recon;
    logic [png_su_pkg::BPP_IDX_W-1:0] bidx;

    // stage 1 moves on when the output register is empty or being drained
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_pix.ready);
    assign i_byte.ready = !r_s1_valid || s1_adv;
    assign accept     = i_byte.valid && i_byte.ready;
    assign sample_acc = accept && !expect_filter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= png_su_pkg::CFG_W'(1);
            r_height <= png_su_pkg::CFG_W'(1);
            r_color  <= png_su_pkg::CT_GRAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                png_su_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                png_su_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                png_su_pkg::CFG_COLOR:  r_color  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    png_su_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data          (i_byte.data_byte),
        .i_width         (r_width),
        .i_height        (r_height),
        .i_color         (r_color),
        .i_bad_filter    (r_bad_filter),
        .o_expect_filter (expect_filter),
        .o_pos           (pos),
        .o_ctl           (s0_ctl)
    );

    // read is issued at accept; write-back happens when the byte leaves stage 1.
    // A filter byte always separates the last write of a row from the first
    // read of the next, so reads never overtake a pending write.
    png_su_line_ram u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_pos),
        .i_wdata (recon),
        .i_re    (sample_acc),
        .i_raddr (pos),
        .o_rdata (above_rd)
    );

    always_comb begin
        bidx   = png_su_pkg::bpp_idx(r_color);
        a_byte = r_left[bidx];
        b_byte = r_s1.first_row ? '0 : above_rd;
        c_byte = r_s1.first_row ? '0 : r_upl[bidx];
    end

    png_su_predict u_pred (
        .i_filter (r_filter),
        .i_x      (r_s1.x),
        .i_a      (a_byte),
        .i_b      (b_byte),
        .i_c      (c_byte),
        .o_r      (recon)
    );

    // row state and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter     <= png_su_pkg::FLT_NONE;
            r_bad_filter <= 1'b0;
            for (int i = 0; i < png_su_pkg::MAX_BPP; i++) begin
                r_left[i] <= '0;
                r_upl[i]  <= '0;
            end
        end else begin
            if (s1_adv) begin
                for (int i = png_su_pkg::MAX_BPP - 1; i > 0; i--) begin
                    r_left[i] <= r_left[i-1];
                    r_upl[i]  <= r_upl[i-1];
                end
                r_left[0] <= recon;
                r_upl[0]  <= b_byte;
            end
            // a filter byte starts a new row: history clears, overriding the shift
            if (accept && expect_filter) begin
                if (i_byte.data_byte <= 8'(png_su_pkg::FLT_PAETH)) begin
                    r_filter     <= png_su_pkg::t_filter'(i_byte.data_byte[2:0]);
                    r_bad_filter <= 1'b0;
                end else begin
                    r_filter     <= png_su_pkg::FLT_NONE;
                    r_bad_filter <= 1'b1;
                end
                for (int i = 0; i < png_su_pkg::MAX_BPP; i++) begin
                    r_left[i] <= '0;
                    r_upl[i]  <= '0;
                end
            end
        end
    end

    // stage 1 and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (sample_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (sample_acc) begin
            r_s1     <= s0_ctl;
            r_s1_pos <= pos;
        end
        if (s1_adv) begin
            r_out_byte    <= recon;
            r_out_row_end <= r_s1.last_col;
            r_out_img_end <= r_s1.last_col && r_s1.last_row;
            r_out_status  <= r_s1.status;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_byte = r_out_byte;
    assign o_pix.row_end    = r_out_row_end;
    assign o_pix.image_end  = r_out_img_end;
    assign o_pix.status     = r_out_status;

`ifndef SYNTHESIS
    // filter bytes never occupy the reconstruct stage
    a_filter_no_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && expect_filter && !r_s1_valid) |=> !r_s1_valid)
        else $error("filter byte entered reconstruct stage");

    // image end is always also a row end
    a_img_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_img_end) |-> r_out_row_end)
        else $error("image end without row end");

    // a stalled reconstruct stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1) && $stable(r_s1_pos)))
        else $error("reconstruct stage lost its item under stall");
`endif

endmodule
